// ===== rtl/spherical_diffusion_rhs_stencil_macros.svh =====
// Assertion macros shared by the stencil RTL files.
// Files that check their own logic include this header; it depends on nothing.
`ifndef SPHERICAL_DIFFUSION_RHS_STENCIL_MACROS_SVH
`define SPHERICAL_DIFFUSION_RHS_STENCIL_MACROS_SVH

`ifndef SYNTHESIS
`define SDRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`define SDRS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);
`else
`define SDRS_ASSERT(lbl, prop, msg)
`define SDRS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/sdrs_pkg.sv =====
// Shared widths, constants, codes and types of the spherical diffusion stencil.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sdrs_pkg;

    localparam int GRID_POINTS   = 128;
    localparam int IDX_W         = 7;
    localparam int IDX_MAX       = (1 << IDX_W) - 1;
    localparam int LAST_INDEX    = (GRID_POINTS - 1 < IDX_MAX) ? GRID_POINTS - 1 : IDX_MAX;

    localparam int CONC_W        = 16;
    localparam int GAIN_W        = 32;
    localparam int FLUX_W        = 16;
    localparam int RATE_W        = 32;
    localparam int FRAC_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam int CENTER_FACTOR = 6;
    localparam int TWO           = 2;

    // Working concentration: unsigned sample or ghost value, kept signed.
    localparam int CV_W          = CONC_W + 2;
    // Stencil sum j*(cR-2c+cL)+(cR-cL) stays below 2^25 in magnitude.
    localparam int S_W           = 26;
    localparam int PROD_W        = GAIN_W + 1 + S_W;
    localparam int T_W           = PROD_W - FRAC_W;

    localparam int FIFO_DEPTH    = 4;

    localparam logic [T_W-1:0] POS_LIMIT = T_W'((64'd1 << (RATE_W - 1)) - 64'd1);
    localparam logic [T_W-1:0] NEG_LIMIT = T_W'(64'd1 << (RATE_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_A,
        CFG_GAIN_B,
        CFG_FLUX_A,
        CFG_FLUX_B
    } t_cfg_reg;

    typedef struct packed {
        logic [IDX_W-1:0]    point_index;
        logic [IDX_W-1:0]    divisor;
        logic                last;
        logic signed [S_W-1:0] s_a;
        logic signed [S_W-1:0] s_b;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_BIAS,
        BK_START,
        BK_WAIT,
        BK_WB
    } t_back_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_ROUND,
        DV_SAT
    } t_div_state;

endpackage

`default_nettype wire

// ===== rtl/sdrs_front.sv =====
// Front end: keeps the two-point window, classifies each point and forms
// the integer stencil sums. Pushes jobs into the queue; depends on sdrs_pkg.
`default_nettype none

module sdrs_front
    import sdrs_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [CONC_W-1:0]        i_conc_a,
    input  wire logic [CONC_W-1:0]        i_conc_b,
    input  wire logic                     i_last_point,
    input  wire logic signed [FLUX_W-1:0] i_flux_a,
    input  wire logic signed [FLUX_W-1:0] i_flux_b,
    input  wire logic                     i_fifo_full,
    output logic                          o_push,
    output t_job                          o_push_data
);

    localparam int D_W  = CV_W + 2;
    localparam int SP_W = D_W + IDX_W + 1;

    function automatic logic signed [S_W-1:0] stencil_sum(
        input logic signed [CV_W-1:0] cl,
        input logic signed [CV_W-1:0] c,
        input logic signed [CV_W-1:0] cr,
        input logic [IDX_W-1:0]       j
    );
        logic signed [D_W-1:0]  d2;
        logic signed [D_W-1:0]  d1;
        logic signed [SP_W-1:0] acc;
        d2  = D_W'(cr) - D_W'(TWO) * D_W'(c) + D_W'(cl);
        d1  = D_W'(cr) - D_W'(cl);
        acc = SP_W'($signed({1'b0, j})) * SP_W'(d2) + SP_W'(d1);
        return acc[S_W-1:0];
    endfunction

    function automatic logic signed [S_W-1:0] center_sum(
        input logic signed [CV_W-1:0] c0,
        input logic signed [CV_W-1:0] c1
    );
        logic signed [D_W-1:0]  d;
        logic signed [SP_W-1:0] acc;
        d   = D_W'(c1) - D_W'(c0);
        acc = SP_W'(d) * SP_W'(CENTER_FACTOR);
        return acc[S_W-1:0];
    endfunction

    logic [CONC_W-1:0] r_older_a, r_newer_a, r_older_b, r_newer_b;
    logic [IDX_W-1:0]  r_count;
    logic              r_pend_valid;
    t_job              r_pend;

    logic                     accept;
    logic                     is_last;
    logic [IDX_W-1:0]         idx_m1;
    logic signed [CV_W-1:0]   ca, cb, older_a, older_b, newer_a, newer_b;
    logic signed [CV_W-1:0]   ghost_a, ghost_b;
    logic                     j1_valid;
    t_job                     j1;
    logic                     pend_set;
    t_job                     pend_job;

    assign o_in_stall = r_pend_valid || i_fifo_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        is_last = i_last_point || (r_count >= IDX_W'(LAST_INDEX));
        idx_m1  = r_count - IDX_W'(1);
        ca      = $signed({2'b00, i_conc_a});
        cb      = $signed({2'b00, i_conc_b});
        older_a = $signed({2'b00, r_older_a});
        older_b = $signed({2'b00, r_older_b});
        newer_a = $signed({2'b00, r_newer_a});
        newer_b = $signed({2'b00, r_newer_b});
        ghost_a = newer_a + CV_W'(i_flux_a);
        ghost_b = newer_b + CV_W'(i_flux_b);

        // Result for the point before the one arriving, or for a lone point of a one-point sweep.
        j1 = '0;
        j1.divisor = IDX_W'(1);
        if (r_count == '0) begin
            // A sweep of a single point yields a zero derivative.
            j1_valid = is_last;
            j1.last  = 1'b1;
        end else if (r_count == IDX_W'(1)) begin
            j1_valid = 1'b1;
            j1.s_a   = center_sum(newer_a, ca);
            j1.s_b   = center_sum(newer_b, cb);
        end else begin
            j1_valid       = 1'b1;
            j1.point_index = idx_m1;
            j1.divisor     = idx_m1;
            j1.s_a         = stencil_sum(older_a, newer_a, ca, idx_m1);
            j1.s_b         = stencil_sum(older_b, newer_b, cb, idx_m1);
        end

        // The surface point's own result, held in r_pend and pushed once the queue has room.
        pend_set             = accept && is_last && (r_count != '0);
        pend_job.point_index = r_count;
        pend_job.divisor     = r_count;
        pend_job.last        = 1'b1;
        pend_job.s_a         = stencil_sum(newer_a, ca, ghost_a, r_count);
        pend_job.s_b         = stencil_sum(newer_b, cb, ghost_b, r_count);

        o_push      = r_pend_valid ? !i_fifo_full : (accept && j1_valid);
        o_push_data = r_pend_valid ? r_pend : j1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older_a    <= '0;
            r_newer_a    <= '0;
            r_older_b    <= '0;
            r_newer_b    <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (is_last) begin
                    r_older_a <= '0;
                    r_newer_a <= '0;
                    r_older_b <= '0;
                    r_newer_b <= '0;
                    r_count   <= '0;
                end else begin
                    r_older_a <= r_newer_a;
                    r_newer_a <= i_conc_a;
                    r_older_b <= r_newer_b;
                    r_newer_b <= i_conc_b;
                    r_count   <= r_count + IDX_W'(1);
                end
            end
            if (pend_set) begin
                r_pend_valid <= 1'b1;
            end else if (r_pend_valid && !i_fifo_full) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_set) begin
            r_pend <= pend_job;
        end
    end

    `include "spherical_diffusion_rhs_stencil_macros.svh"

    `SDRS_ASSERT(a_pend_at_sweep_start, r_pend_valid |-> (r_count == '0), "surface job pending mid sweep")

endmodule

`default_nettype wire

// ===== rtl/sdrs_fifo.sv =====
// Short job queue between the front end and the arithmetic back end.
// Register storage with one write and one read port; depends on sdrs_pkg.
`default_nettype none

module sdrs_fifo
    import sdrs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_push_data,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_data,
    input  wire logic i_pop
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_job             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr, n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        n_rd_ptr = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `include "spherical_diffusion_rhs_stencil_macros.svh"

    `SDRS_ASSERT_NEVER(a_no_overflow, i_push && o_full && !i_pop, "job pushed into a full queue")
    `SDRS_ASSERT_NEVER(a_no_underflow, i_pop && !o_valid, "job popped from an empty queue")

endmodule

`default_nettype wire

// ===== rtl/sdrs_div.sv =====
// Bit-serial signed divider by the grid index with floor rounding and
// saturation to the rate width. One lane per species; depends on sdrs_pkg.
`default_nettype none

module sdrs_div
    import sdrs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic signed [T_W-1:0] i_dividend,
    input  wire logic [IDX_W-1:0]      i_divisor,
    output logic                       o_done,
    output logic [RATE_W-1:0]          o_quot
);

    localparam int CNT_W = $clog2(T_W);

    t_div_state        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_div;
    logic [IDX_W-1:0]  r_rem;
    logic [T_W-1:0]    r_quo;
    logic              r_neg;
    logic              r_done;
    logic [RATE_W-1:0] r_result;

    logic              load_en, step_en, round_en, sat_en, last_step;
    logic [T_W-1:0]    mag;
    logic [IDX_W:0]    trial, rem_next;
    logic              ge;
    logic [RATE_W-1:0] sat_val;

    assign last_step = (r_cnt == CNT_W'(T_W - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE:  if (i_start) n_state = DV_RUN;
            DV_RUN:   if (last_step) n_state = DV_ROUND;
            DV_ROUND: n_state = DV_SAT;
            DV_SAT:   n_state = DV_IDLE;
            default:  n_state = DV_IDLE;
        endcase
    end

    always_comb begin
        load_en  = 1'b0;
        step_en  = 1'b0;
        round_en = 1'b0;
        sat_en   = 1'b0;
        case (r_state)
            DV_IDLE:  load_en  = i_start;
            DV_RUN:   step_en  = 1'b1;
            DV_ROUND: round_en = 1'b1;
            DV_SAT:   sat_en   = 1'b1;
            default:  ;
        endcase
    end

    always_comb begin
        mag      = i_dividend[T_W-1] ? (~i_dividend + T_W'(1)) : i_dividend;
        trial    = {r_rem, r_quo[T_W-1]};
        ge       = (trial >= {1'b0, r_div});
        rem_next = ge ? (trial - {1'b0, r_div}) : trial;
        // Floor of a negative quotient is one further from zero when inexact.
        if (!r_neg) begin
            sat_val = (r_quo > POS_LIMIT) ? {1'b0, {(RATE_W - 1){1'b1}}}
                                          : r_quo[RATE_W-1:0];
        end else begin
            sat_val = (r_quo > NEG_LIMIT) ? {1'b1, {(RATE_W - 1){1'b0}}}
                                          : RATE_W'(0) - r_quo[RATE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= sat_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_neg <= i_dividend[T_W-1];
            r_quo <= mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= '0;
        end
        if (step_en) begin
            r_rem <= rem_next[IDX_W-1:0];
            r_quo <= {r_quo[T_W-2:0], ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (round_en) begin
            r_quo <= r_quo + T_W'(r_neg && (r_rem != '0));
        end
        if (sat_en) begin
            r_result <= sat_val;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_result;

endmodule

`default_nettype wire

// ===== rtl/sdrs_back.sv =====
// Back end: takes one job from the queue, multiplies by the gains, adds the
// rounding bias and divides in two lanes, then fills the output register.
// Depends on sdrs_pkg and sdrs_div.
`default_nettype none

module sdrs_back
    import sdrs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [GAIN_W-1:0] i_gain_a,
    input  wire logic [GAIN_W-1:0] i_gain_b,
    input  wire logic              i_fifo_valid,
    input  wire t_job              i_fifo_data,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [IDX_W-1:0]       o_point_index,
    output logic [RATE_W-1:0]      o_rate_a,
    output logic [RATE_W-1:0]      o_rate_b,
    output logic                   o_last_result
);

    t_back_state             r_state, n_state;
    t_job                    r_job;
    logic signed [PROD_W-1:0] r_prod_a, r_prod_b;
    logic signed [T_W-1:0]   r_t_a, r_t_b;
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_index;
    logic [RATE_W-1:0]       r_out_rate_a, r_out_rate_b;
    logic                    r_out_last;

    logic                    mul_en, bias_en, div_start, wb_load, out_free;
    logic                    div_done_a, div_done_b;
    logic [RATE_W-1:0]       quot_a, quot_b;
    logic signed [PROD_W-1:0] bias, sum_a, sum_b;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:  if (i_fifo_valid) n_state = BK_MUL;
            BK_MUL:   n_state = BK_BIAS;
            BK_BIAS:  n_state = BK_START;
            BK_START: n_state = BK_WAIT;
            BK_WAIT:  if (div_done_a) n_state = BK_WB;
            BK_WB:    if (out_free) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        mul_en    = 1'b0;
        bias_en   = 1'b0;
        div_start = 1'b0;
        wb_load   = 1'b0;
        case (r_state)
            BK_IDLE:  o_pop     = i_fifo_valid;
            BK_MUL:   mul_en    = 1'b1;
            BK_BIAS:  bias_en   = 1'b1;
            BK_START: div_start = 1'b1;
            BK_WB:    wb_load   = out_free;
            default:  ;
        endcase
    end

    // Adding half the divisor before the floor gives round half up.
    always_comb begin
        bias  = $signed({{(PROD_W - IDX_W){1'b0}}, r_job.divisor}) <<< (FRAC_W - 1);
        sum_a = r_prod_a + bias;
        sum_b = r_prod_b + bias;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wb_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_fifo_data;
        end
        if (mul_en) begin
            r_prod_a <= PROD_W'($signed({1'b0, i_gain_a})) * PROD_W'($signed(r_job.s_a));
            r_prod_b <= PROD_W'($signed({1'b0, i_gain_b})) * PROD_W'($signed(r_job.s_b));
        end
        if (bias_en) begin
            r_t_a <= sum_a[PROD_W-1:FRAC_W];
            r_t_b <= sum_b[PROD_W-1:FRAC_W];
        end
        if (wb_load) begin
            r_out_index  <= r_job.point_index;
            r_out_rate_a <= quot_a;
            r_out_rate_b <= quot_b;
            r_out_last   <= r_job.last;
        end
    end

    sdrs_div u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_t_a),
        .i_divisor  (r_job.divisor),
        .o_done     (div_done_a),
        .o_quot     (quot_a)
    );

    sdrs_div u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_t_b),
        .i_divisor  (r_job.divisor),
        .o_done     (div_done_b),
        .o_quot     (quot_b)
    );

    assign o_out_valid   = r_out_valid;
    assign o_point_index = r_out_index;
    assign o_rate_a      = r_out_rate_a;
    assign o_rate_b      = r_out_rate_b;
    assign o_last_result = r_out_last;

    `include "spherical_diffusion_rhs_stencil_macros.svh"

    `SDRS_ASSERT(a_lanes_in_step, div_done_a == div_done_b, "divider lanes out of step")
    `SDRS_ASSERT(a_done_while_waiting, div_done_a |-> (r_state == BK_WAIT), "divide ended outside wait")

endmodule

`default_nettype wire

// ===== rtl/spherical_diffusion_rhs_stencil.sv =====
// Spherical diffusion stencil: points of a radial sweep enter from the center
// outward, and each beat out carries one point's time derivative for species
// A and B, one point behind the input; the surface point gives two beats, or one
// if it is the only point. The time of each derivative is set by the bit-serial
// divide by the grid index (one quotient bit a cycle over 43 bits, both species in
// parallel lanes). Inputs enter at one a cycle until the four-entry job queue fills
// or a surface point's own job waits. Write the gain and flux registers only while
// the block is idle. Depends on sdrs_pkg, sdrs_front, sdrs_fifo, sdrs_back.
`default_nettype none

module spherical_diffusion_rhs_stencil
    import sdrs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [CONC_W-1:0]     i_conc_a,
    input  wire logic [CONC_W-1:0]     i_conc_b,
    input  wire logic                  i_last_point,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [IDX_W-1:0]           o_point_index,
    output logic signed [RATE_W-1:0]   o_rate_a,
    output logic signed [RATE_W-1:0]   o_rate_b,
    output logic                       o_last_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [GAIN_W-1:0]        r_gain_a, r_gain_b;
    logic signed [FLUX_W-1:0] r_flux_a, r_flux_b;

    logic              fifo_full, fifo_valid, push, pop;
    t_job              push_data, fifo_data;
    logic [RATE_W-1:0] rate_a, rate_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_a <= '0;
            r_gain_b <= '0;
            r_flux_a <= '0;
            r_flux_b <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_GAIN_A: r_gain_a <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_B: r_gain_b <= i_cfg_data[GAIN_W-1:0];
                CFG_FLUX_A: r_flux_a <= i_cfg_data[FLUX_W-1:0];
                CFG_FLUX_B: r_flux_b <= i_cfg_data[FLUX_W-1:0];
                default:    ;
            endcase
        end
    end

    sdrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_conc_a     (i_conc_a),
        .i_conc_b     (i_conc_b),
        .i_last_point (i_last_point),
        .i_flux_a     (r_flux_a),
        .i_flux_b     (r_flux_b),
        .i_fifo_full  (fifo_full),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    sdrs_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (fifo_full),
        .o_valid     (fifo_valid),
        .o_data      (fifo_data),
        .i_pop       (pop)
    );

    sdrs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_gain_a      (r_gain_a),
        .i_gain_b      (r_gain_b),
        .i_fifo_valid  (fifo_valid),
        .i_fifo_data   (fifo_data),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_point_index (o_point_index),
        .o_rate_a      (rate_a),
        .o_rate_b      (rate_b),
        .o_last_result (o_last_result)
    );

    assign o_rate_a = $signed(rate_a);
    assign o_rate_b = $signed(rate_b);

endmodule

`default_nettype wire

// ===== dv/tb_spherical_diffusion_rhs_stencil.sv =====
// Self-checking testbench for the spherical diffusion stencil: directed sweeps, then
// random sweeps under three idling mixes, checked beat by beat by a scoreboard class.
// Depends on sdrs_pkg and the spherical_diffusion_rhs_stencil RTL.
`default_nettype none

module tb_spherical_diffusion_rhs_stencil;
    import sdrs_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_POINTS  = 470;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [IDX_W-1:0]  point_index;
        logic [RATE_W-1:0] rate_a;
        logic [RATE_W-1:0] rate_b;
        logic              last_result;
    } t_rate_beat;

    class rhs_scoreboard;
        logic [GAIN_W-1:0] gain_a, gain_b;
        longint            flux_a, flux_b;
        longint            older_a, newer_a, older_b, newer_b;
        int unsigned       next_index;
        t_rate_beat        due_rates[$];
        int                errors;

        function new();
            gain_a = '0;
            gain_b = '0;
            flux_a = 0;
            flux_b = 0;
            older_a = 0;
            newer_a = 0;
            older_b = 0;
            newer_b = 0;
            next_index = 0;
            errors = 0;
        endfunction

        // Round num/den to nearest, ties toward plus infinity, then clamp to 32 bits.
        function logic [RATE_W-1:0] round_sat(longint num, longint den);
            longint n2, d2, q, hi, lo;
            n2 = TWO * num + den;
            d2 = TWO * den;
            q = n2 / d2;
            if ((n2 % d2) != 0 && n2 < 0) q = q - 1;
            hi = (longint'(1) <<< (RATE_W - 1)) - 1;
            lo = -(longint'(1) <<< (RATE_W - 1));
            if (q > hi) q = hi;
            if (q < lo) q = lo;
            return q[RATE_W-1:0];
        endfunction

        function logic [RATE_W-1:0] center_rate(logic [GAIN_W-1:0] gain, longint c0, longint c1);
            longint g;
            g = gain;
            return round_sat(CENTER_FACTOR * g * (c1 - c0), longint'(1) <<< FRAC_W);
        endfunction

        function logic [RATE_W-1:0] stencil_rate(logic [GAIN_W-1:0] gain, longint cl,
                                                  longint c, longint cr, int unsigned j);
            longint g, jj, s;
            g = gain;
            jj = j;
            s = jj * (cr - TWO * c + cl) + (cr - cl);
            return round_sat(g * s, jj <<< FRAC_W);
        endfunction

        function void set_reg(t_cfg_reg r, logic [CFG_DATA_W-1:0] d);
            case (r)
                CFG_GAIN_A: gain_a = d;
                CFG_GAIN_B: gain_b = d;
                CFG_FLUX_A: flux_a = $signed(d[FLUX_W-1:0]);
                CFG_FLUX_B: flux_b = $signed(d[FLUX_W-1:0]);
                default: ;
            endcase
        endfunction

        function int pending();
            return due_rates.size();
        endfunction

        function void note_point(logic [CONC_W-1:0] ca, logic [CONC_W-1:0] cb, logic last);
            t_rate_beat  b;
            int unsigned idx;
            bit          is_last;
            longint      a_now, b_now;
            idx = next_index;
            is_last = last || (idx >= LAST_INDEX);
            a_now = ca;
            b_now = cb;
            if (idx == 1) begin
                b.point_index = '0;
                b.rate_a = center_rate(gain_a, newer_a, a_now);
                b.rate_b = center_rate(gain_b, newer_b, b_now);
                b.last_result = 1'b0;
                due_rates.push_back(b);
            end else if (idx > 1) begin
                b.point_index = IDX_W'(idx - 1);
                b.rate_a = stencil_rate(gain_a, older_a, newer_a, a_now, idx - 1);
                b.rate_b = stencil_rate(gain_b, older_b, newer_b, b_now, idx - 1);
                b.last_result = 1'b0;
                due_rates.push_back(b);
            end
            if (is_last) begin
                // A lone surface point has no neighbors and reports a zero derivative.
                b.point_index = IDX_W'(idx);
                b.last_result = 1'b1;
                if (idx == 0) begin
                    b.rate_a = '0;
                    b.rate_b = '0;
                end else begin
                    b.rate_a = stencil_rate(gain_a, newer_a, a_now, newer_a + flux_a, idx);
                    b.rate_b = stencil_rate(gain_b, newer_b, b_now, newer_b + flux_b, idx);
                end
                due_rates.push_back(b);
                older_a = 0;
                newer_a = 0;
                older_b = 0;
                newer_b = 0;
                next_index = 0;
            end else begin
                older_a = newer_a;
                older_b = newer_b;
                newer_a = a_now;
                newer_b = b_now;
                next_index = idx + 1;
            end
        endfunction

        function void check_rate(logic [IDX_W-1:0] idx, logic [RATE_W-1:0] ra,
                                 logic [RATE_W-1:0] rb, logic last);
            t_rate_beat e;
            if (due_rates.size() == 0) begin
                $error("unexpected result beat: point_index %0d", idx);
                errors++;
                return;
            end
            e = due_rates.pop_front();
            if (idx !== e.point_index) begin
                $error("point_index mismatch: expected %0d, actual %0d", e.point_index, idx);
                errors++;
            end
            if (ra !== e.rate_a) begin
                $error("rate_a mismatch: expected %0d, actual %0d",
                       $signed(e.rate_a), $signed(ra));
                errors++;
            end
            if (rb !== e.rate_b) begin
                $error("rate_b mismatch: expected %0d, actual %0d",
                       $signed(e.rate_b), $signed(rb));
                errors++;
            end
            if (last !== e.last_result) begin
                $error("last_result mismatch: expected %0d, actual %0d", e.last_result, last);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [CONC_W-1:0]        i_conc_a = '0;
    logic [CONC_W-1:0]        i_conc_b = '0;
    logic                     i_last_point = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [IDX_W-1:0]         o_point_index;
    logic signed [RATE_W-1:0] o_rate_a;
    logic signed [RATE_W-1:0] o_rate_b;
    logic                     o_last_result;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;

    rhs_scoreboard sb = new();

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    spherical_diffusion_rhs_stencil dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_conc_a      (i_conc_a),
        .i_conc_b      (i_conc_b),
        .i_last_point  (i_last_point),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_point_index (o_point_index),
        .o_rate_a      (o_rate_a),
        .o_rate_b      (o_rate_b),
        .o_last_result (o_last_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: check each accepted beat, then pick the stall for the next cycle.
    // A long hold-off request from the main process is counted down here.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_rate(o_point_index, o_rate_a, o_rate_b, o_last_result);
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    function automatic logic [CONC_W-1:0] pick_conc();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return CONC_W'($urandom);
        endcase
    endfunction

    task automatic send_point(logic [CONC_W-1:0] ca, logic [CONC_W-1:0] cb, logic last);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_conc_a     <= ca;
        i_conc_b     <= cb;
        i_last_point <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_point(ca, cb, last);
    endtask

    task automatic configure(logic [GAIN_W-1:0] ga, logic [GAIN_W-1:0] gb,
                             logic [FLUX_W-1:0] fa, logic [FLUX_W-1:0] fb);
        logic [CFG_DATA_W-1:0] vals [4];
        t_cfg_reg              r;
        vals[0] = ga;
        vals[1] = gb;
        // The flux registers only use the low half; the upper bits are noise.
        vals[2] = {16'($urandom), fa};
        vals[3] = {16'($urandom), fb};
        for (int k = 0; k < 4; k++) begin
            r = t_cfg_reg'(k);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= r;
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_reg(r, vals[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_rates_done();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // A first point of a sweep yields no beat, so give the block time to go idle.
    task automatic settle();
        wait_rates_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int target);
        int sent, len;
        bit held, paused;
        sent = 0;
        held = 0;
        paused = 0;
        while (sent < target) begin
            if (!held && sent >= target / 2) begin
                hold_req = HOLD_CYCLES;
                held = 1;
            end
            if (!paused && sent >= (3 * target) / 4) begin
                wait_rates_done();
                paused = 1;
            end
            if ($urandom_range(99) < 82) begin
                // Well-formed sweep; now and then one long enough to hit the last index.
                len = ($urandom_range(19) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    send_point(pick_conc(), pick_conc(), k == len - 1);
            end else begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    send_point(pick_conc(), pick_conc(), 1'($urandom_range(1)));
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(32'h0001_0000, 32'h0003_8000, 16'h7FFF, 16'h8000);
        send_point(16'h1234, 16'hABCD, 1'b1);
        send_point(16'h0000, 16'hFFFF, 1'b0);
        send_point(16'hFFFF, 16'h0000, 1'b1);
        // The surface ghost leaves the concentration range on both species.
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'hFFFF, 16'h0000, 1'b0);
        send_point(16'h0000, 16'hFFFF, 1'b1);
        settle();

        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF);
        send_point(16'h0000, 16'hFFFF, 1'b0);
        send_point(16'hFFFF, 16'h0000, 1'b0);
        send_point(16'h0000, 16'hFFFF, 1'b0);
        send_point(16'hFFFF, 16'h0000, 1'b1);
        send_point(16'hFFFF, 16'hFFFF, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b1);
        settle();

        configure(32'h0000_0000, 32'h0000_0000, 16'h0001, 16'hFFFF);
        send_point(16'hFFFF, 16'h0000, 1'b0);
        send_point(16'h0000, 16'hFFFF, 1'b0);
        send_point(16'h5A5A, 16'hA5A5, 1'b1);
        settle();

        tx_idle_pct = 11;
        rx_idle_pct = 67;
        configure(GAIN_W'($urandom_range(0, 32'h000F_FFFF)), GAIN_W'($urandom),
                  FLUX_W'($urandom), FLUX_W'($urandom));
        run_phase(PHASE_POINTS);
        settle();

        tx_idle_pct = 67;
        rx_idle_pct = 11;
        configure(32'hFFFF_FFFF, GAIN_W'($urandom_range(0, 32'h0003_FFFF)), 16'h7FFF, 16'h8000);
        run_phase(PHASE_POINTS);
        settle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(GAIN_W'($urandom), 32'h0000_0000, FLUX_W'($urandom), FLUX_W'($urandom));
        run_phase(PHASE_POINTS);
        settle();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
